FILE: design/sensor_frame_deframer_top_assert.svh
// Assertion macros used by the deframer core module.
// Simulation gets real concurrent assertions; synthesis sees empty bodies.
`ifndef SENSOR_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define SENSOR_FRAME_DEFRAMER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define SFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sensor frame deframer assertion failed");

`define SFD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("sensor frame deframer assertion failed");

`else

`define SFD_ASSERT(label, clk, rst_n, prop)

`define SFD_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

FILE: design/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int PAYLOAD_BYTES      = 8;
    localparam int PAYLOAD_COUNT_W    = 4;
    localparam int PAYLOAD_IDX_W      = 3;
    localparam int SAMPLE_SLOTS       = 6;
    localparam int SAMPLE_W           = 10;
    localparam int SAMPLE_COUNT_DEF   = 6;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 16;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_BYTE    = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;

    localparam logic [1:0] SYNC_HUNT  = 2'd0;
    localparam logic [1:0] SYNC_FIRST = 2'd1;
    localparam logic [1:0] SYNC_BOTH  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [7:0]  SYNC_FIRST_RESET    = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND_RESET   = 8'h5A;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd12000;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  sample_0;
        logic [9:0]  sample_1;
        logic [9:0]  sample_2;
        logic [9:0]  sample_3;
        logic [9:0]  sample_4;
        logic [9:0]  sample_5;
        logic [31:0] requests_seen;
        logic [31:0] timeouts_seen;
        logic [31:0] bad_frames_seen;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] timeout_ticks;
    } cfg_t;

endpackage

FILE: design/sfd_cfg_regs.sv
`timescale 1ns / 1ps

module sfd_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output sfd_pkg::cfg_t                      cfg
);

    sfd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= sfd_pkg::SYNC_FIRST_RESET;
            cfg_reg.sync_second   <= sfd_pkg::SYNC_SECOND_RESET;
            cfg_reg.timeout_ticks <= sfd_pkg::TIMEOUT_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sfd_pkg::REG_SYNC_FIRST:    cfg_reg.sync_first    <= cfg_data[7:0];
                sfd_pkg::REG_SYNC_SECOND:   cfg_reg.sync_second   <= cfg_data[7:0];
                sfd_pkg::REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: design/sfd_in_stage.sv
`timescale 1ns / 1ps

module sfd_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sfd_pkg::in_item_t in_data,
    output logic              item_valid,
    output sfd_pkg::in_item_t item,
    input  logic              item_take
);

    logic              valid_reg;
    logic              valid_next;
    sfd_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (item_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
    end

endmodule

FILE: design/sfd_core.sv
`timescale 1ns / 1ps
`include "sensor_frame_deframer_top_assert.svh"

module sfd_core
#(
    parameter int SAMPLE_COUNT = sfd_pkg::SAMPLE_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  sfd_pkg::cfg_t      cfg,
    input  logic               item_valid,
    input  sfd_pkg::in_item_t  item,
    output logic               item_take,
    output logic               out_valid,
    input  logic               out_ready,
    output sfd_pkg::out_item_t out_data
);

    logic                                armed_reg, armed_next;
    logic [1:0]                          sync_stage_reg, sync_stage_next;
    logic [sfd_pkg::PAYLOAD_COUNT_W-1:0] payload_count_reg, payload_count_next;
    logic [7:0]                          running_xor_reg, running_xor_next;
    logic [15:0]                         elapsed_ticks_reg, elapsed_ticks_next;
    logic [31:0]                         request_total_reg, request_total_next;
    logic [31:0]                         timeout_total_reg, timeout_total_next;
    logic [31:0]                         bad_total_reg, bad_total_next;
    logic [7:0]                          payload_byte_reg [sfd_pkg::PAYLOAD_BYTES];
    logic                                byte_we;
    logic [15:0]                         elapsed_inc;
    logic [sfd_pkg::PAYLOAD_BYTES*8-1:0] payload_word;
    logic [sfd_pkg::SAMPLE_W-1:0]        sample_val [sfd_pkg::SAMPLE_SLOTS];
    logic                                emit;
    logic                                with_samples;
    logic [1:0]                          status;
    logic                                out_valid_reg;
    sfd_pkg::out_item_t                  out_data_reg, result;

    assign item_take   = item_valid && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign elapsed_inc = elapsed_ticks_reg + 16'd1;

    always_comb
    begin
        for (int i = 0; i < sfd_pkg::PAYLOAD_BYTES; i++)
            payload_word[8*i +: 8] = payload_byte_reg[i];
        for (int i = 0; i < sfd_pkg::SAMPLE_SLOTS; i++)
        begin
            if (with_samples && i < SAMPLE_COUNT)
                sample_val[i] = payload_word[sfd_pkg::SAMPLE_W*i +: sfd_pkg::SAMPLE_W];
            else
                sample_val[i] = '0;
        end
    end

    always_comb
    begin
        armed_next         = armed_reg;
        sync_stage_next    = sync_stage_reg;
        payload_count_next = payload_count_reg;
        running_xor_next   = running_xor_reg;
        elapsed_ticks_next = elapsed_ticks_reg;
        request_total_next = request_total_reg;
        timeout_total_next = timeout_total_reg;
        bad_total_next     = bad_total_reg;
        byte_we            = 1'b0;
        emit               = 1'b0;
        with_samples       = 1'b0;
        status             = sfd_pkg::STATUS_GOOD;

        unique case (item.command)
            sfd_pkg::CMD_REQUEST:
            begin
                armed_next         = 1'b1;
                sync_stage_next    = sfd_pkg::SYNC_HUNT;
                payload_count_next = '0;
                running_xor_next   = '0;
                elapsed_ticks_next = '0;
                request_total_next = request_total_reg + 32'd1;
            end
            sfd_pkg::CMD_TICK:
            begin
                if (armed_reg)
                begin
                    elapsed_ticks_next = elapsed_inc;
                    if (elapsed_inc >= cfg.timeout_ticks)
                    begin
                        timeout_total_next = timeout_total_reg + 32'd1;
                        armed_next         = 1'b0;
                        emit               = 1'b1;
                        status             = sfd_pkg::STATUS_TIMEOUT;
                    end
                end
            end
            sfd_pkg::CMD_BYTE:
            begin
                if (armed_reg)
                begin
                    priority if (sync_stage_reg == sfd_pkg::SYNC_FIRST)
                    begin
                        if (item.rx_byte == cfg.sync_second)
                            sync_stage_next = sfd_pkg::SYNC_BOTH;
                        else if (item.rx_byte == cfg.sync_first)
                            sync_stage_next = sfd_pkg::SYNC_FIRST;
                        else
                            sync_stage_next = sfd_pkg::SYNC_HUNT;
                    end
                    else if (sync_stage_reg != sfd_pkg::SYNC_BOTH)
                    begin
                        if (item.rx_byte == cfg.sync_first)
                            sync_stage_next = sfd_pkg::SYNC_FIRST;
                        else
                            sync_stage_next = sfd_pkg::SYNC_HUNT;
                    end
                    else if (payload_count_reg <
                             sfd_pkg::PAYLOAD_COUNT_W'(sfd_pkg::PAYLOAD_BYTES))
                    begin
                        byte_we            = 1'b1;
                        running_xor_next   = running_xor_reg ^ item.rx_byte;
                        payload_count_next = payload_count_reg + 1'b1;
                    end
                    else if (item.rx_byte != running_xor_reg)
                    begin
                        bad_total_next     = bad_total_reg + 32'd1;
                        sync_stage_next    = sfd_pkg::SYNC_HUNT;
                        payload_count_next = '0;
                        running_xor_next   = '0;
                        emit               = 1'b1;
                        status             = sfd_pkg::STATUS_BAD;
                    end
                    else
                    begin
                        armed_next   = 1'b0;
                        emit         = 1'b1;
                        with_samples = 1'b1;
                        status       = sfd_pkg::STATUS_GOOD;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.status          = status;
        result.sample_0        = sample_val[0];
        result.sample_1        = sample_val[1];
        result.sample_2        = sample_val[2];
        result.sample_3        = sample_val[3];
        result.sample_4        = sample_val[4];
        result.sample_5        = sample_val[5];
        result.requests_seen   = request_total_next;
        result.timeouts_seen   = timeout_total_next;
        result.bad_frames_seen = bad_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg         <= 1'b0;
            sync_stage_reg    <= sfd_pkg::SYNC_HUNT;
            payload_count_reg <= '0;
            running_xor_reg   <= '0;
            elapsed_ticks_reg <= '0;
            request_total_reg <= '0;
            timeout_total_reg <= '0;
            bad_total_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                armed_reg         <= armed_next;
                sync_stage_reg    <= sync_stage_next;
                payload_count_reg <= payload_count_next;
                running_xor_reg   <= running_xor_next;
                elapsed_ticks_reg <= elapsed_ticks_next;
                request_total_reg <= request_total_next;
                timeout_total_reg <= timeout_total_next;
                bad_total_reg     <= bad_total_next;
                out_valid_reg     <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && byte_we)
            payload_byte_reg[payload_count_reg[sfd_pkg::PAYLOAD_IDX_W-1:0]] <= item.rx_byte;
        if (item_take && emit)
            out_data_reg <= result;
    end

    `SFD_ASSERT(a_count_bounded, clk, rst_n,
        payload_count_reg <= sfd_pkg::PAYLOAD_COUNT_W'(sfd_pkg::PAYLOAD_BYTES))
    `SFD_ASSERT(a_payload_after_sync, clk, rst_n,
        (payload_count_reg != '0) |-> (sync_stage_reg == sfd_pkg::SYNC_BOTH))
    `SFD_ASSERT_NEXT(a_good_disarms, clk, rst_n,
        item_take && emit && with_samples, !armed_reg && out_valid_reg)
    `SFD_ASSERT_NEXT(a_timeout_counted, clk, rst_n,
        item_take && emit && status == sfd_pkg::STATUS_TIMEOUT,
        timeout_total_reg == $past(timeout_total_reg) + 32'd1)

endmodule

FILE: design/sensor_frame_deframer_top.sv
`timescale 1ns / 1ps

// Sensor frame deframer. A request transaction arms the receiver; byte
// transactions are then searched for the two-byte sync word, eight payload bytes
// are collected and an XOR checksum byte closes the frame. A good frame returns
// six 10-bit samples, a checksum mismatch or a timeout (counted in tick
// transactions) returns a status with zero samples, and every result carries the
// request, timeout and bad-frame counters. One input transaction is taken every
// clock cycle while the result register is empty or being read. An accepted
// input is held in the input register, the parser works on it combinationally
// and its result is loaded into the result register when the item is taken. The
// input register advances whenever the result register is empty or being read,
// so a pending result only stalls the input once a second item is waiting behind
// it. Configuration registers are written through the cfg channel, which is
// always ready, and must only be written while idle.
module sensor_frame_deframer_top
#(
    parameter int SAMPLE_COUNT = sfd_pkg::SAMPLE_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sfd_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sfd_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sfd_pkg::cfg_t     cfg;
    logic              item_valid;
    logic              item_take;
    sfd_pkg::in_item_t item;

    sfd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    sfd_core
    #(
        .SAMPLE_COUNT (SAMPLE_COUNT)
    )
    u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
